// File: hw/rtl/ot_pkg.sv
package ot_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    localparam logic signed [2:0] PRIO_DISCARD = -3'sd1;

    localparam logic ACT_LOCAL  = 1'b0;
    localparam logic ACT_REMOTE = 1'b1;

    typedef struct packed {
        logic [15:0]       pos;
        logic [7:0]        ch;
        logic signed [2:0] prio;
    } edit_t;

    typedef struct packed {
        logic [15:0]       pos;
        logic [7:0]        ch;
        logic signed [2:0] prio;
        logic [31:0]       stamp;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
        logic   rd_en;
        idx_t   rd_addr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRD,
        ST_DCHK,
        ST_XE,
        ST_XP,
        ST_TRD,
        ST_TCHK,
        ST_DONE
    } state_t;

    function automatic idx_t idx_inc(idx_t x);
        if (x == idx_t'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return x + idx_t'(1);
    endfunction

    function automatic idx_t idx_add(idx_t h, cnt_t c);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(h) + (CNT_W + 1)'(c);
        if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/ot_pend_mem.sv
module ot_pend_mem (
    input  logic             aclk,
    input  ot_pkg::mem_req_t req,
    output ot_pkg::entry_t   rd_data
);
    import ot_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // The read data holds until the next read, so an entry stays visible while it is worked on.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/ot_xform.sv
module ot_xform (
    input  ot_pkg::edit_t a,
    input  ot_pkg::edit_t b,
    output ot_pkg::edit_t r
);
    import ot_pkg::*;

    logic eq_diff;
    logic keep;
    logic shift;

    assign eq_diff = (a.pos == b.pos) && (a.ch != b.ch);
    assign keep    = (a.pos < b.pos) || (eq_diff && ($signed(a.prio) < $signed(b.prio)));
    assign shift   = (a.pos > b.pos) || (eq_diff && ($signed(a.prio) > $signed(b.prio)));

    always_comb begin
        r = a;
        priority if (keep) begin
            r = a;
        end else if (shift) begin
            r.pos = (a.pos == 16'hFFFF) ? a.pos : a.pos + 16'd1;
        end else begin
            // An exact tie cancels the edit but leaves its position alone.
            r.prio = PRIO_DISCARD;
        end
    end

endmodule

// File: hw/rtl/ot_pending_op_transformer.sv
// Channel  | Direction | Handshake          | Carries
// s_*      | in        | s_valid / s_ready  | local or remote edit request
// m_*      | out       | m_valid / m_ready  | edit to send or edit to apply
// cfg_*    | in        | cfg_wr_en          | site priority, no wait
//
// A local edit is accepted in ST_IDLE, which also appends it to the pending queue
// unless the queue is full, and then loads the output register in ST_DONE.
// A remote edit first drops stale head entries, each after a registered read and a
// check, until the queue is empty or an entry is not stale, then transforms entries
// up to the last one or one the remote has already seen; each transformed entry costs
// a registered read, a check and two passes through the single transform unit.
// Synchronous reset empties the queue, clears both counters and sets priority to 1.
// A held result stalls only the finish; the next request is still accepted.
module ot_pending_op_transformer (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic              s_op_kind,
    input  logic [15:0]       s_edit_position,
    input  logic [7:0]        s_edit_char,
    input  logic signed [2:0] s_origin_priority,
    input  logic [31:0]       s_remote_sent_stamp,
    input  logic [31:0]       s_remote_seen_stamp,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_out_action,
    output logic              m_out_kind,
    output logic [15:0]       m_out_position,
    output logic [7:0]        m_out_char,
    output logic signed [2:0] m_out_priority,
    output logic [31:0]       m_out_sent_stamp,
    output logic [31:0]       m_out_seen_stamp,
    output logic              m_discarded,
    output logic              m_queue_overflow
);
    import ot_pkg::*;

    state_t      state_reg, state_next;
    idx_t        head_reg;
    cnt_t        count_reg;
    cnt_t        i_reg;
    idx_t        slot_reg;
    logic [31:0] sent_reg;
    logic [31:0] recv_reg;
    logic [1:0]  site_prio_reg;

    logic        act_reg;
    logic        kind_reg;
    edit_t       e_reg;
    logic [31:0] sstamp_reg;
    logic [31:0] seen_reg;
    logic        ovf_reg;

    logic              m_valid_reg;
    logic              out_action_reg;
    logic              out_kind_reg;
    logic [15:0]       out_pos_reg;
    logic [7:0]        out_char_reg;
    logic signed [2:0] out_prio_reg;
    logic [31:0]       out_sstamp_reg;
    logic [31:0]       out_seen_reg;
    logic              out_disc_reg;
    logic              out_ovf_reg;

    mem_req_t mem_req;
    entry_t   rd_entry;
    edit_t    pend;
    edit_t    xf_a, xf_b, xf_r;

    logic accept;
    logic stale;
    logic more;
    logic out_load;
    logic q_full;

    ot_pend_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_entry)
    );

    ot_xform u_xform (
        .a (xf_a),
        .b (xf_b),
        .r (xf_r)
    );

    assign pend     = '{pos: rd_entry.pos, ch: rd_entry.ch, prio: rd_entry.prio};
    assign stale    = (rd_entry.stamp <= seen_reg);
    assign more     = ((i_reg + cnt_t'(1)) < count_reg);
    assign out_load = !m_valid_reg || m_ready;
    assign q_full   = (count_reg == DEPTH_CNT);
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_action == ACT_REMOTE) ? ST_DRD : ST_DONE;
                end
            end
            ST_DRD:  state_next = (count_reg == '0) ? ST_DONE : ST_DCHK;
            ST_DCHK: state_next = stale ? ST_DRD : ST_XE;
            ST_XE:   state_next = ST_XP;
            ST_XP:   state_next = more ? ST_TRD : ST_DONE;
            ST_TRD:  state_next = ST_TCHK;
            ST_TCHK: state_next = stale ? ST_DONE : ST_XE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        mem_req = '0;
        xf_a    = e_reg;
        xf_b    = pend;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_action == ACT_LOCAL) && !q_full) begin
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_addr       = idx_add(head_reg, count_reg);
                    mem_req.wr_data.pos   = s_edit_position;
                    mem_req.wr_data.ch    = s_edit_char;
                    mem_req.wr_data.prio  = $signed({1'b0, site_prio_reg});
                    mem_req.wr_data.stamp = sent_reg + 32'd1;
                end
            end
            ST_DRD: begin
                mem_req.rd_en   = (count_reg != '0);
                mem_req.rd_addr = head_reg;
            end
            ST_XP: begin
                // The entry is moved against the edit as it stands after its own step.
                xf_a                  = pend;
                xf_b                  = e_reg;
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = slot_reg;
                mem_req.wr_data.pos   = xf_r.pos;
                mem_req.wr_data.ch    = rd_entry.ch;
                mem_req.wr_data.prio  = xf_r.prio;
                mem_req.wr_data.stamp = rd_entry.stamp;
            end
            ST_TRD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = slot_reg;
            end
            ST_DCHK, ST_XE, ST_TCHK, ST_DONE: begin
                s_ready = 1'b0;
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sent_reg      <= '0;
            recv_reg      <= '0;
            site_prio_reg <= 2'd1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                site_prio_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        act_reg    <= s_action;
                        kind_reg   <= s_op_kind;
                        e_reg.pos  <= s_edit_position;
                        e_reg.ch   <= s_edit_char;
                        if (s_action == ACT_LOCAL) begin
                            sent_reg   <= sent_reg + 32'd1;
                            e_reg.prio <= $signed({1'b0, site_prio_reg});
                            sstamp_reg <= sent_reg + 32'd1;
                            seen_reg   <= recv_reg;
                            ovf_reg    <= q_full;
                            if (!q_full) begin
                                count_reg <= count_reg + cnt_t'(1);
                            end
                        end else begin
                            e_reg.prio <= s_origin_priority;
                            sstamp_reg <= s_remote_sent_stamp;
                            seen_reg   <= s_remote_seen_stamp;
                            ovf_reg    <= 1'b0;
                        end
                    end
                end
                ST_DCHK: begin
                    if (stale) begin
                        head_reg  <= idx_inc(head_reg);
                        count_reg <= count_reg - cnt_t'(1);
                    end else begin
                        i_reg    <= '0;
                        slot_reg <= head_reg;
                    end
                end
                ST_XE: begin
                    e_reg <= xf_r;
                end
                ST_XP: begin
                    i_reg    <= i_reg + cnt_t'(1);
                    slot_reg <= idx_inc(slot_reg);
                end
                ST_DONE: begin
                    if (out_load) begin
                        out_action_reg <= act_reg;
                        out_kind_reg   <= kind_reg;
                        out_pos_reg    <= e_reg.pos;
                        out_char_reg   <= e_reg.ch;
                        out_prio_reg   <= e_reg.prio;
                        out_sstamp_reg <= sstamp_reg;
                        out_seen_reg   <= seen_reg;
                        out_disc_reg   <= (act_reg == ACT_REMOTE) && (e_reg.prio == PRIO_DISCARD);
                        out_ovf_reg    <= ovf_reg;
                        if (act_reg == ACT_REMOTE) begin
                            recv_reg <= recv_reg + 32'd1;
                        end
                    end
                end
                ST_DRD, ST_TRD, ST_TCHK: begin
                    head_reg <= head_reg;
                end
                default: begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_action     = out_action_reg;
    assign m_out_kind       = out_kind_reg;
    assign m_out_position   = out_pos_reg;
    assign m_out_char       = out_char_reg;
    assign m_out_priority   = out_prio_reg;
    assign m_out_sent_stamp = out_sstamp_reg;
    assign m_out_seen_stamp = out_seen_reg;
    assign m_discarded      = out_disc_reg;
    assign m_queue_overflow = out_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("pending count beyond queue depth");

    a_local_append: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_action == ACT_LOCAL) && !q_full |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("local request not appended to the pending queue");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XP) |-> (i_reg < count_reg))
        else $error("transform step beyond the pending entries");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_ovf_reg && out_disc_reg))
        else $error("overflow and discard flagged together");

    a_remote_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && out_load && (act_reg == ACT_REMOTE)
            |=> recv_reg == $past(recv_reg) + 32'd1)
        else $error("received counter did not advance for a remote request");

endmodule

// File: tb/sv/tb_ot_pending_op_transformer.sv
module tb_ot_pending_op_transformer;
    timeunit 1ns;
    timeprecision 1ps;

    import ot_pkg::*;

    localparam logic       KIND_INSERT    = 1'b0;
    localparam logic       KIND_DELETE    = 1'b1;
    localparam logic [1:0] SITE_PRIO_LOW  = 2'd1;
    localparam logic [1:0] SITE_PRIO_HIGH = 2'd2;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         DRAIN_LIMIT    = 20000;
    localparam int         PHASE_ITEMS    = 305;

    typedef struct {
        logic              action;
        logic              kind;
        logic [15:0]       pos;
        logic [7:0]        ch;
        logic signed [2:0] prio;
        logic [31:0]       sent;
        logic [31:0]       seen;
    } edit_request_t;

    typedef struct {
        logic              action;
        logic              kind;
        logic [15:0]       pos;
        logic [7:0]        ch;
        logic signed [2:0] prio;
        logic [31:0]       sent;
        logic [31:0]       seen;
        logic              discarded;
        logic              overflow;
    } edit_outcome_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [1:0]        cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_action;
    logic              s_op_kind;
    logic [15:0]       s_edit_position;
    logic [7:0]        s_edit_char;
    logic signed [2:0] s_origin_priority;
    logic [31:0]       s_remote_sent_stamp;
    logic [31:0]       s_remote_seen_stamp;
    logic              m_valid;
    logic              m_ready;
    logic              m_out_action;
    logic              m_out_kind;
    logic [15:0]       m_out_position;
    logic [7:0]        m_out_char;
    logic signed [2:0] m_out_priority;
    logic [31:0]       m_out_sent_stamp;
    logic [31:0]       m_out_seen_stamp;
    logic              m_discarded;
    logic              m_queue_overflow;

    // Mirror of the block's state.
    entry_t      queue_mirror [QUEUE_DEPTH];
    int          mirror_head;
    int          mirror_count;
    logic [31:0] sent_ctr;
    logic [31:0] recv_ctr;
    logic [1:0]  site_prio;
    logic [31:0] far_sent;

    edit_outcome_t awaited_edits[$];

    int gap_pct;
    int stall_pct;
    int error_count;
    int results_checked;
    int n_local;
    int n_remote;
    int n_discarded;
    int n_overflow;
    int n_settings;

    ot_pending_op_transformer dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_op_kind           (s_op_kind),
        .s_edit_position     (s_edit_position),
        .s_edit_char         (s_edit_char),
        .s_origin_priority   (s_origin_priority),
        .s_remote_sent_stamp (s_remote_sent_stamp),
        .s_remote_seen_stamp (s_remote_seen_stamp),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_out_action        (m_out_action),
        .m_out_kind          (m_out_kind),
        .m_out_position      (m_out_position),
        .m_out_char          (m_out_char),
        .m_out_priority      (m_out_priority),
        .m_out_sent_stamp    (m_out_sent_stamp),
        .m_out_seen_stamp    (m_out_seen_stamp),
        .m_discarded         (m_discarded),
        .m_queue_overflow    (m_queue_overflow)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Transform of edit a against edit b: keep, shift right, or discard on a tie.
    function automatic edit_t shift_against(edit_t a, edit_t b);
        edit_t r;
        logic  split;
        logic  keep;
        logic  shift;
        r     = a;
        split = (a.pos == b.pos) && (a.ch != b.ch);
        keep  = (a.pos < b.pos) || (split && ($signed(a.prio) < $signed(b.prio)));
        shift = (a.pos > b.pos) || (split && ($signed(a.prio) > $signed(b.prio)));
        if (shift) begin
            r.pos = (a.pos == 16'hFFFF) ? 16'hFFFF : a.pos + 16'd1;
        end else if (!keep) begin
            r.prio = PRIO_DISCARD;
        end
        return r;
    endfunction

    function automatic edit_outcome_t predict_outcome(edit_request_t r);
        edit_outcome_t o;
        edit_t         e;
        edit_t         p;
        int            slot;
        e.pos       = r.pos;
        e.ch        = r.ch;
        o.action    = r.action;
        o.kind      = r.kind;
        o.discarded = 1'b0;
        o.overflow  = 1'b0;
        if (r.action == ACT_LOCAL) begin
            sent_ctr = sent_ctr + 32'd1;
            e.prio   = $signed({1'b0, site_prio});
            o.sent   = sent_ctr;
            o.seen   = recv_ctr;
            n_local++;
            if (mirror_count >= QUEUE_DEPTH) begin
                o.overflow = 1'b1;
                n_overflow++;
            end else begin
                slot = (mirror_head + mirror_count) % QUEUE_DEPTH;
                queue_mirror[slot].pos   = e.pos;
                queue_mirror[slot].ch    = e.ch;
                queue_mirror[slot].prio  = e.prio;
                queue_mirror[slot].stamp = sent_ctr;
                mirror_count++;
            end
        end else begin
            e.prio = r.prio;
            o.sent = r.sent;
            o.seen = r.seen;
            n_remote++;
            // Entries the remote has already seen leave the front of the queue.
            while (mirror_count > 0 && queue_mirror[mirror_head].stamp <= r.seen) begin
                mirror_head = (mirror_head + 1) % QUEUE_DEPTH;
                mirror_count--;
            end
            for (int i = 0; i < mirror_count; i++) begin
                slot = (mirror_head + i) % QUEUE_DEPTH;
                if (queue_mirror[slot].stamp <= r.seen) begin
                    break;
                end
                p.pos  = queue_mirror[slot].pos;
                p.ch   = queue_mirror[slot].ch;
                p.prio = queue_mirror[slot].prio;
                e = shift_against(e, p);
                p = shift_against(p, e);
                queue_mirror[slot].pos  = p.pos;
                queue_mirror[slot].prio = p.prio;
            end
            recv_ctr    = recv_ctr + 32'd1;
            o.discarded = (e.prio == PRIO_DISCARD);
            if (o.discarded) begin
                n_discarded++;
            end
        end
        o.pos  = e.pos;
        o.ch   = e.ch;
        o.prio = e.prio;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40) begin
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    always @(posedge aclk) begin
        edit_outcome_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_edits.size() == 0) begin
                report_mismatch("result with no request outstanding", 32'(m_out_position),
                                32'd0);
            end else begin
                want = awaited_edits[0];
                awaited_edits.delete(0);
                results_checked++;
                check_field("out_action", 32'(m_out_action), 32'(want.action));
                check_field("out_kind", 32'(m_out_kind), 32'(want.kind));
                check_field("out_position", 32'(m_out_position), 32'(want.pos));
                check_field("out_char", 32'(m_out_char), 32'(want.ch));
                check_field("out_priority", 32'(m_out_priority), 32'(want.prio));
                check_field("out_sent_stamp", m_out_sent_stamp, want.sent);
                check_field("out_seen_stamp", m_out_seen_stamp, want.seen);
                check_field("discarded", 32'(m_discarded), 32'(want.discarded));
                check_field("queue_overflow", 32'(m_queue_overflow), 32'(want.overflow));
            end
        end
    end

    // Result-side back-pressure in random bursts.
    initial begin
        int burst;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 17);
                repeat (burst) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic issue_edit(input edit_request_t r);
        int burst;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_valid <= 1'b0;
            burst = $urandom_range(1, 17);
            repeat (burst) @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_action            <= r.action;
        s_op_kind           <= r.kind;
        s_edit_position     <= r.pos;
        s_edit_char         <= r.ch;
        s_origin_priority   <= r.prio;
        s_remote_sent_stamp <= r.sent;
        s_remote_seen_stamp <= r.seen;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        awaited_edits.insert(awaited_edits.size(), predict_outcome(r));
        @(negedge aclk);
    endtask

    // Stops the sender and waits until every awaited result has come back or DRAIN_LIMIT is reached.
    task automatic settle_idle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (awaited_edits.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_priority(input logic [1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        site_prio = value;
        n_settings++;
    endtask

    function automatic edit_request_t make_edit(logic action, logic kind, logic [15:0] pos,
                                               logic [7:0] ch, logic signed [2:0] prio,
                                               logic [31:0] sent, logic [31:0] seen);
        edit_request_t r;
        r.action = action;
        r.kind   = kind;
        r.pos    = pos;
        r.ch     = ch;
        r.prio   = prio;
        r.sent   = sent;
        r.seen   = seen;
        return r;
    endfunction

    function automatic edit_request_t random_edit();
        edit_request_t r;
        int            roll;
        int            pick;
        roll     = $urandom_range(0, 99);
        r.action = (roll < 46) ? ACT_LOCAL : ACT_REMOTE;
        r.kind   = 1'($urandom_range(0, 1));
        pick     = $urandom_range(0, 99);
        if (pick < 80) begin
            r.pos = 16'($urandom_range(0, 31));
        end else if (pick < 88) begin
            r.pos = 16'($urandom_range(16'hFFF8, 16'hFFFF));
        end else begin
            r.pos = 16'($urandom());
        end
        r.ch   = ($urandom_range(0, 9) < 7) ? 8'(8'h61 + $urandom_range(0, 3))
                                            : 8'($urandom_range(0, 255));
        r.prio = 3'($urandom_range(0, 3) - 1);
        r.sent = $urandom();
        r.seen = $urandom();
        // Most remote requests come from a well-behaved peer: its own stamps count up and
        // it has seen every one of this site's edits that is no longer pending.
        if (r.action == ACT_REMOTE && roll < 88) begin
            far_sent = far_sent + 32'd1;
            r.sent   = far_sent;
            r.seen   = sent_ctr - $urandom_range(0, mirror_count);
            if ($urandom_range(0, 9) == 0) begin
                r.prio = PRIO_DISCARD;
            end else begin
                r.prio = $signed({1'b0, 2'd3 - site_prio});
            end
        end
        return r;
    endfunction

    // Fills the queue past its depth, then sends a remote request across the full queue and one that empties it.
    task automatic test_queue_overflow();
        logic [15:0] pos;
        logic [7:0]  ch;
        settle_idle();
        write_priority(SITE_PRIO_HIGH);
        for (int i = 0; i <= QUEUE_DEPTH; i++) begin
            pos = (i == 0) ? 16'd0 : (i == 1) ? 16'hFFFF : 16'(i * 3);
            ch  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'h60 + 8'(i);
            issue_edit(make_edit(ACT_LOCAL, (i % 2 == 0) ? KIND_INSERT : KIND_DELETE, pos, ch,
                                 (i % 2 == 0) ? PRIO_DISCARD : 3'sd0,
                                 (i % 2 == 0) ? 32'hFFFF_FFFF : 32'd0,
                                 (i % 2 == 0) ? 32'hFFFF_FFFF : 32'd0));
        end
        // At the top position every shift saturates.
        issue_edit(make_edit(ACT_REMOTE, KIND_DELETE, 16'hFFFF, 8'h7E, 3'sd1,
                             32'hFFFF_FFFF, 32'd0));
        // An edit that arrives already discarded, with all pending entries acknowledged.
        issue_edit(make_edit(ACT_REMOTE, KIND_INSERT, 16'd0, 8'h00, PRIO_DISCARD,
                             32'd1, sent_ctr));
    endtask

    task automatic test_tie_breaks();
        settle_idle();
        write_priority(SITE_PRIO_HIGH);
        // Same position and character: the remote edit is cancelled.
        issue_edit(make_edit(ACT_LOCAL, KIND_INSERT, 16'd5, 8'h78, 3'sd0, 32'd0, 32'd0));
        issue_edit(make_edit(ACT_REMOTE, KIND_INSERT, 16'd5, 8'h78, 3'sd1,
                             32'd2, sent_ctr - 32'd1));
        // Same position, different characters: the lower priority keeps its place.
        issue_edit(make_edit(ACT_LOCAL, KIND_INSERT, 16'd7, 8'h61, 3'sd0, 32'd0, 32'd0));
        issue_edit(make_edit(ACT_REMOTE, KIND_DELETE, 16'd7, 8'h62, 3'sd1,
                             32'd3, sent_ctr - 32'd1));
        // Equal priorities at the same position also cancel the remote edit.
        issue_edit(make_edit(ACT_LOCAL, KIND_DELETE, 16'd9, 8'h63, 3'sd0, 32'd0, 32'd0));
        issue_edit(make_edit(ACT_REMOTE, KIND_INSERT, 16'd9, 8'h64, 3'sd2,
                             32'd4, sent_ctr - 32'd1));
        // Nothing acknowledged: transformed against every entry still pending.
        issue_edit(make_edit(ACT_REMOTE, KIND_INSERT, 16'd3, 8'h71, 3'sd1, 32'd5, 32'd0));
        issue_edit(make_edit(ACT_REMOTE, KIND_DELETE, 16'd8, 8'h71, 3'sd2, 32'd6, 32'd0));
    endtask

    task automatic test_random_traffic(input logic [1:0] prio, input int idle_pct);
        settle_idle();
        write_priority(prio);
        gap_pct   = idle_pct;
        stall_pct = idle_pct;
        repeat (PHASE_ITEMS) issue_edit(random_edit());
    endtask

    initial begin
        s_valid             = 1'b0;
        s_action            = ACT_LOCAL;
        s_op_kind           = KIND_INSERT;
        s_edit_position     = '0;
        s_edit_char         = '0;
        s_origin_priority   = '0;
        s_remote_sent_stamp = '0;
        s_remote_seen_stamp = '0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = SITE_PRIO_LOW;
        aresetn             = 1'b0;
        mirror_head         = 0;
        mirror_count        = 0;
        sent_ctr            = '0;
        recv_ctr            = '0;
        site_prio           = SITE_PRIO_LOW;
        far_sent            = '0;
        gap_pct             = 25;
        stall_pct           = 25;
        error_count         = 0;
        results_checked     = 0;
        n_local             = 0;
        n_remote            = 0;
        n_discarded         = 0;
        n_overflow          = 0;
        n_settings          = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_queue_overflow();
        test_tie_breaks();
        test_random_traffic(SITE_PRIO_LOW, 25);
        test_random_traffic(SITE_PRIO_HIGH, 50);
        test_random_traffic(SITE_PRIO_LOW, 0);
        test_random_traffic(SITE_PRIO_HIGH, 12);
        test_random_traffic(SITE_PRIO_LOW, 35);
        test_random_traffic(SITE_PRIO_HIGH, 0);

        settle_idle();
        if (awaited_edits.size() != 0) begin
            report_mismatch("results never delivered", awaited_edits.size(), 0);
        end
        $display("Checked %0d results: %0d local edits (%0d hit a full queue), %0d remote edits",
                 results_checked, n_local, n_overflow, n_remote);
        $display("%0d remote edits ended discarded; site priority written %0d times",
                 n_discarded, n_settings);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timeout with %0d results still outstanding", awaited_edits.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
